### sv/pdisp_pkg.sv
// Package for the periodic task dispatcher.
// Holds item kinds, status codes, sequencer states and table entry types.
// No dependencies.
package pdisp_pkg;

  parameter int SLOTS_DEFAULT = 8;
  parameter int MAX_DISPATCH  = 8;
  parameter int NDW           = $clog2(MAX_DISPATCH + 1);

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_REG    = 3'd1,
    KIND_ENABLE = 3'd2,
    KIND_RUN    = 3'd3,
    KIND_RSTAT  = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOSLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OP,
    S_CLR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        en;
    logic [31:0] period;
    logic [31:0] stamp;
  } cfg_ent_t;

  typedef struct packed {
    logic [31:0] longest;
    logic [31:0] runs;
  } stat_ent_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic        dispatch;
    logic        en;
    logic [31:0] period;
    logic [31:0] longest;
    logic [31:0] runs;
  } res_t;

endpackage

### sv/pdisp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds until the next read enable. No dependencies.
module pdisp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/periodic_task_dispatcher.sv
// Periodic task dispatcher top level: sequencer around two slot tables.
// Depends on pdisp_pkg and pdisp_ram.
//
// Usage: one input stream (s_axis) carries commands, kind in tuser. Every
// command but kinds 6 and 7 yields one or more result beats on m_axis, the
// final one flagged by tlast. Commands are handled one at a time; s_axis_tready
// is high only while the sequencer is idle.
// States from the accepted beat to the last result beat:
//   register, or any command on an unregistered slot: IDLE, FIN
//   set enable, run report, read: IDLE, OP, FIN
//   tick: IDLE, SCAN per slot (at most slots registered), FIN; at most 8
//     dispatches; one slot per cycle via the table read port unless stalled
//   reset statistics: IDLE, CLR (one table row cleared a cycle), FIN
// A result sits in an output register, so a stalled receiver only holds the
// sequencer when a second result must be pushed behind it.
// Reset clears the registered slot count and the sequencer; the tables are
// not cleared, since slots are written on registration before any read.
// Slot configuration (enable, period, last tick) and statistics (longest
// run, dispatch count) live in two RAMs; enable, run and tick updates are read, modify, write.
module periodic_task_dispatcher #(
  parameter int SLOTS = pdisp_pkg::SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_ms[31:0], slot[34:32], period[66:35], enable[67], run_us[99:68]
  input  logic [103:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_out[2:0], enabled_out[3], period_out[35:4], longest_run_us[67:36],
  // run_total[99:68], slots_used_out[103:100]
  output logic [103:0] m_axis_tdata,
  // status[1:0], dispatch[2]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW = $clog2(SLOTS + 1);
  localparam int VW = (UW > 3) ? UW : 3;
  localparam int NDW = pdisp_pkg::NDW;

  pdisp_pkg::state_t state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [NDW-1:0]    ndisp, ndisp_next;
  logic [UW-1:0]     used, used_next;
  pdisp_pkg::res_t   held, held_next;
  logic              hvalid, hvalid_next;

  pdisp_pkg::kind_t  kind_r;
  logic [31:0]       now_r;
  logic [2:0]        slot_r;
  logic              en_r;
  logic [31:0]       run_r;

  pdisp_pkg::res_t   m_res;
  logic              m_last;
  logic [3:0]        m_used;

  logic              push, push_last;
  pdisp_pkg::res_t   push_res;
  logic              out_free;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  cfg_we, st_we;
  logic [IW-1:0]         waddr;
  pdisp_pkg::cfg_ent_t   cfg_wd, cfg_rd;
  pdisp_pkg::stat_ent_t  st_wd, st_rd;

  logic              accept;
  pdisp_pkg::kind_t  in_kind;
  logic [31:0]       in_period;
  logic [2:0]        in_slot;
  logic              in_valid_slot;
  logic [31:0]       elapsed;
  logic              due;
  logic [NDW-1:0]    ndisp_inc;
  logic              more;

  pdisp_ram #(
    .WIDTH ($bits(pdisp_pkg::cfg_ent_t)),
    .DEPTH (SLOTS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (waddr),
    .wdata (cfg_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cfg_rd)
  );

  pdisp_ram #(
    .WIDTH ($bits(pdisp_pkg::stat_ent_t)),
    .DEPTH (SLOTS)
  ) u_stat_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (st_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rd)
  );

  assign s_axis_tready = (state == pdisp_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_kind       = pdisp_pkg::kind_t'(s_axis_tuser);
  assign in_slot       = s_axis_tdata[34:32];
  assign in_period     = s_axis_tdata[66:35];
  assign in_valid_slot = VW'(in_slot) < VW'(used);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign elapsed   = now_r - cfg_rd.stamp;
  assign due       = cfg_rd.en && (elapsed >= cfg_rd.period);
  assign ndisp_inc = ndisp + NDW'(due);
  assign more      = ((UW'(idx) + UW'(1)) < used) &&
                     (ndisp_inc < NDW'(pdisp_pkg::MAX_DISPATCH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pdisp_pkg::S_IDLE;
      used   <= '0;
      hvalid <= 1'b0;
    end else begin
      state  <= state_next;
      used   <= used_next;
      hvalid <= hvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    ndisp <= ndisp_next;
    held  <= held_next;
    if (accept) begin
      kind_r <= in_kind;
      now_r  <= s_axis_tdata[31:0];
      slot_r <= in_slot;
      en_r   <= s_axis_tdata[67];
      run_r  <= s_axis_tdata[99:68];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_res  <= push_res;
      m_last <= push_last;
      m_used <= 4'(used);
    end
  end

  assign m_axis_tdata = {m_used, m_res.runs, m_res.longest, m_res.period,
                         m_res.en, m_res.slot};
  assign m_axis_tuser = {m_res.dispatch, m_res.status};
  assign m_axis_tlast = m_last;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    ndisp_next  = ndisp;
    used_next   = used;
    held_next   = held;
    hvalid_next = hvalid;
    rd_en       = 1'b0;
    rd_addr     = idx;
    cfg_we      = 1'b0;
    st_we       = 1'b0;
    waddr       = idx;
    cfg_wd      = cfg_rd;
    st_wd       = st_rd;
    push        = 1'b0;
    push_last   = 1'b0;
    push_res    = held;

    unique case (state)
      pdisp_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_kind) inside
            pdisp_pkg::KIND_TICK: begin
              ndisp_next  = '0;
              hvalid_next = 1'b0;
              idx_next    = '0;
              if (used == '0) begin
                state_next = pdisp_pkg::S_FIN;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = pdisp_pkg::S_SCAN;
              end
            end
            pdisp_pkg::KIND_REG: begin
              held_next   = '0;
              hvalid_next = 1'b1;
              state_next  = pdisp_pkg::S_FIN;
              if (used >= UW'(SLOTS)) begin
                held_next.status = pdisp_pkg::ST_FULL;
              end else begin
                waddr            = IW'(used);
                cfg_we           = 1'b1;
                st_we            = 1'b1;
                cfg_wd.en        = 1'b1;
                cfg_wd.period    = in_period;
                cfg_wd.stamp     = '0;
                st_wd            = '0;
                held_next.status = pdisp_pkg::ST_OK;
                held_next.slot   = 3'(used);
                held_next.en     = 1'b1;
                held_next.period = in_period;
                used_next        = used + UW'(1);
              end
            end
            pdisp_pkg::KIND_ENABLE, pdisp_pkg::KIND_RUN, pdisp_pkg::KIND_READ: begin
              if (in_valid_slot) begin
                rd_en      = 1'b1;
                rd_addr    = IW'(in_slot);
                idx_next   = IW'(in_slot);
                state_next = pdisp_pkg::S_OP;
              end else begin
                held_next        = '0;
                held_next.status = pdisp_pkg::ST_NOSLOT;
                held_next.slot   = in_slot;
                hvalid_next      = 1'b1;
                state_next       = pdisp_pkg::S_FIN;
              end
            end
            pdisp_pkg::KIND_RSTAT: begin
              hvalid_next = 1'b0;
              idx_next    = '0;
              state_next  = (used == '0) ? pdisp_pkg::S_FIN : pdisp_pkg::S_CLR;
            end
            default: begin
              state_next = pdisp_pkg::S_IDLE;
            end
          endcase
        end
      end

      pdisp_pkg::S_SCAN: begin
        // stall only when a dispatch must push the previous one out
        if (!(due && hvalid && !out_free)) begin
          if (due) begin
            cfg_we           = 1'b1;
            st_we            = 1'b1;
            cfg_wd.stamp     = now_r;
            st_wd.runs       = st_rd.runs + 32'd1;
            push             = hvalid;
            held_next        = '0;
            held_next.status   = pdisp_pkg::ST_OK;
            held_next.slot     = 3'(idx);
            held_next.dispatch = 1'b1;
            held_next.en       = cfg_rd.en;
            held_next.period   = cfg_rd.period;
            held_next.longest  = st_rd.longest;
            held_next.runs     = st_rd.runs + 32'd1;
            hvalid_next        = 1'b1;
            ndisp_next         = ndisp_inc;
          end
          if (more) begin
            rd_en    = 1'b1;
            rd_addr  = IW'(UW'(idx) + UW'(1));
            idx_next = IW'(UW'(idx) + UW'(1));
          end else begin
            state_next = pdisp_pkg::S_FIN;
          end
        end
      end

      pdisp_pkg::S_OP: begin
        held_next         = '0;
        held_next.status  = pdisp_pkg::ST_OK;
        held_next.slot    = slot_r;
        held_next.en      = cfg_rd.en;
        held_next.period  = cfg_rd.period;
        held_next.longest = st_rd.longest;
        held_next.runs    = st_rd.runs;
        hvalid_next       = 1'b1;
        state_next        = pdisp_pkg::S_FIN;
        case (kind_r)
          pdisp_pkg::KIND_ENABLE: begin
            cfg_we       = 1'b1;
            cfg_wd.en    = en_r;
            held_next.en = en_r;
          end
          pdisp_pkg::KIND_RUN: begin
            if (run_r > st_rd.longest) begin
              st_we             = 1'b1;
              st_wd.longest     = run_r;
              held_next.longest = run_r;
            end
          end
          default: begin
          end
        endcase
      end

      pdisp_pkg::S_CLR: begin
        st_we = 1'b1;
        st_wd = '0;
        if ((UW'(idx) + UW'(1)) < used) begin
          idx_next = IW'(UW'(idx) + UW'(1));
        end else begin
          state_next = pdisp_pkg::S_FIN;
        end
      end

      pdisp_pkg::S_FIN: begin
        if (out_free) begin
          push        = 1'b1;
          push_last   = 1'b1;
          push_res    = hvalid ? held : '0;
          hvalid_next = 1'b0;
          state_next  = pdisp_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pdisp_pkg::S_IDLE;
      end
    endcase
  end

endmodule
